@@ rtl/sle_pkg.sv @@
// ----------------------------------------------------------------------------
// sle_pkg: shared types and codes for the sequential list engine
// Operation and status codes, field widths and the command and status
// groups between the controller and the datapath.
// ----------------------------------------------------------------------------
package sle_pkg;

  localparam int DEPTH_DEF = 64;

  localparam int OP_W  = 3;
  localparam int VAL_W = 32;
  localparam int POS_W = 7;
  localparam int ST_W  = 3;

  localparam logic [OP_W-1:0] OP_PUSH_BACK  = 3'd0;
  localparam logic [OP_W-1:0] OP_POP_BACK   = 3'd1;
  localparam logic [OP_W-1:0] OP_PUSH_FRONT = 3'd2;
  localparam logic [OP_W-1:0] OP_POP_FRONT  = 3'd3;
  localparam logic [OP_W-1:0] OP_FIND       = 3'd4;
  localparam logic [OP_W-1:0] OP_INSERT     = 3'd5;
  localparam logic [OP_W-1:0] OP_ERASE      = 3'd6;

  localparam logic [ST_W-1:0] ST_OK       = 3'd0;
  localparam logic [ST_W-1:0] ST_FULL     = 3'd1;
  localparam logic [ST_W-1:0] ST_EMPTY    = 3'd2;
  localparam logic [ST_W-1:0] ST_BADPOS   = 3'd3;
  localparam logic [ST_W-1:0] ST_NOTFOUND = 3'd4;

  // controller to datapath
  typedef struct packed {
    logic load;       // capture the request
    logic walk_init;  // set up the entry walk
    logic walk;       // walk in progress
    logic finish;     // apply the request and register the result
  } sle_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic walk_req;   // request needs a walk over the entries
    logic walk_more;  // reads still to issue
    logic pend;       // a read is still being shifted or compared
  } sle_sts_t;

endpackage

@@ rtl/sle_ctrl.sv @@
// ----------------------------------------------------------------------------
// sle_ctrl: request sequencer
// Accepts one request, steps it through check, walk (when needed) and
// finish, and holds the result valid until the receiving side takes it.
// ----------------------------------------------------------------------------
module sle_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  output logic               out_valid,
  input  logic               out_stall,
  input  sle_pkg::sle_sts_t  sts,
  output sle_pkg::sle_cmd_t  cmd
);

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_CHECK  = 2'd1;
  localparam logic [1:0] S_WALK   = 2'd2;
  localparam logic [1:0] S_FINISH = 2'd3;

  logic [1:0] state_r;
  logic [1:0] state_nxt;
  logic       out_valid_r;
  logic       out_valid_nxt;
  logic       out_free;

  // the result register may be overwritten once its transaction is done
  assign out_free = !out_valid_r || !out_stall;

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;

  assign cmd.load      = (state_r == S_IDLE) && in_valid;
  assign cmd.walk_init = (state_r == S_CHECK) && sts.walk_req;
  assign cmd.walk      = (state_r == S_WALK);
  assign cmd.finish    = (state_r == S_FINISH) && out_free;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) state_nxt = S_CHECK;
      end
      S_CHECK: begin
        state_nxt = sts.walk_req ? S_WALK : S_FINISH;
      end
      S_WALK: begin
        if (!sts.walk_more && !sts.pend) state_nxt = S_FINISH;
      end
      S_FINISH: begin
        if (out_free) state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.finish) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

@@ rtl/sle_dpath.sv @@
// ----------------------------------------------------------------------------
// sle_dpath: list storage and walk datapath
// Entry memory with one write and one registered read port, the entry
// count, the walk pointer and the result registers.
// ----------------------------------------------------------------------------
module sle_dpath #(
  parameter int DEPTH = sle_pkg::DEPTH_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  sle_pkg::sle_cmd_t                  cmd,
  output sle_pkg::sle_sts_t                  sts,
  input  logic        [sle_pkg::OP_W-1:0]    in_op,
  input  logic signed [sle_pkg::VAL_W-1:0]   in_value,
  input  logic        [sle_pkg::POS_W-1:0]   in_position,
  output logic        [sle_pkg::ST_W-1:0]    out_status,
  output logic        [sle_pkg::POS_W-1:0]   out_found_position,
  output logic        [sle_pkg::POS_W-1:0]   out_count
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam int XW = ((CW > sle_pkg::POS_W) ? CW : sle_pkg::POS_W) + 1;

  logic [sle_pkg::VAL_W-1:0] mem [DEPTH];

  logic        [sle_pkg::OP_W-1:0]  op_r;
  logic signed [sle_pkg::VAL_W-1:0] value_r;
  logic        [sle_pkg::POS_W-1:0] pos_r;
  logic [CW-1:0]                    cnt_r;
  logic [CW-1:0]                    cnt_nxt;
  logic [CW-1:0]                    left_r;
  logic [AW-1:0]                    ptr_r;
  logic                             pend_r;
  logic [AW-1:0]                    pend_idx_r;
  logic [sle_pkg::VAL_W-1:0]        rd_data_r;
  logic                             hit_r;
  logic [sle_pkg::POS_W-1:0]        found_r;
  logic [sle_pkg::POS_W-1:0]        found_nxt;
  logic [sle_pkg::ST_W-1:0]         status_r;
  logic [sle_pkg::POS_W-1:0]        found_out_r;
  logic [sle_pkg::POS_W-1:0]        count_out_r;

  logic [XW-1:0]             cnt_x;
  logic [XW-1:0]             pos_x;
  logic [CW-1:0]             pos_m1;
  logic [CW-1:0]             at_c;
  logic                      is_full;
  logic                      is_empty;
  logic                      ins_bad;
  logic                      ers_bad;
  logic                      is_open;
  logic                      is_close;
  logic                      is_find;
  logic                      is_grow;
  logic                      is_shrink;
  logic [sle_pkg::ST_W-1:0]  chk_status;
  logic [sle_pkg::ST_W-1:0]  fin_status;
  logic [CW-1:0]             left_init;
  logic [AW-1:0]             ptr_init;
  logic [AW-1:0]             ptr_step;
  logic [AW-1:0]             wr_tgt;
  logic                      walk_more;
  logic                      rd_en;
  logic                      match;
  logic                      val_we;
  logic [AW-1:0]             val_wa;
  logic                      sh_we;
  logic                      mem_we;
  logic [AW-1:0]             mem_wa;
  logic [sle_pkg::VAL_W-1:0] mem_wd;

  assign cnt_x    = XW'(cnt_r);
  assign pos_x    = XW'(pos_r);
  assign pos_m1   = CW'(pos_x - XW'(1));
  assign is_full  = (cnt_r == CW'(DEPTH));
  assign is_empty = (cnt_r == '0);
  assign ins_bad  = (pos_r == '0) || (pos_x > cnt_x + XW'(1));
  assign ers_bad  = (pos_r == '0) || (pos_x > cnt_x);

  assign is_open   = (op_r == sle_pkg::OP_PUSH_FRONT) || (op_r == sle_pkg::OP_INSERT);
  assign is_close  = (op_r == sle_pkg::OP_POP_FRONT) || (op_r == sle_pkg::OP_ERASE);
  assign is_find   = (op_r == sle_pkg::OP_FIND);
  assign is_grow   = (op_r == sle_pkg::OP_PUSH_BACK) || is_open;
  assign is_shrink = (op_r == sle_pkg::OP_POP_BACK) || is_close;

  // gap position: position less one for insert and erase, front otherwise
  assign at_c = ((op_r == sle_pkg::OP_INSERT) || (op_r == sle_pkg::OP_ERASE)) ? pos_m1 : '0;

  always_comb begin
    chk_status = sle_pkg::ST_OK;
    unique case (op_r) inside
      sle_pkg::OP_PUSH_BACK, sle_pkg::OP_PUSH_FRONT: begin
        if (is_full) chk_status = sle_pkg::ST_FULL;
      end
      sle_pkg::OP_POP_BACK, sle_pkg::OP_POP_FRONT: begin
        if (is_empty) chk_status = sle_pkg::ST_EMPTY;
      end
      sle_pkg::OP_INSERT: begin
        if (is_full) chk_status = sle_pkg::ST_FULL;
        else if (ins_bad) chk_status = sle_pkg::ST_BADPOS;
      end
      sle_pkg::OP_ERASE: begin
        if (is_empty) chk_status = sle_pkg::ST_EMPTY;
        else if (ers_bad) chk_status = sle_pkg::ST_BADPOS;
      end
      default: begin
        chk_status = sle_pkg::ST_OK;
      end
    endcase
  end

  assign fin_status = is_find ? (hit_r ? sle_pkg::ST_OK : sle_pkg::ST_NOTFOUND) : chk_status;

  // open walks downwards from the last entry, close and find walk upwards
  always_comb begin
    if (is_open) begin
      left_init = cnt_r - at_c;
      ptr_init  = AW'(cnt_r - CW'(1));
    end else if (is_close) begin
      left_init = cnt_r - CW'(1) - at_c;
      ptr_init  = AW'(at_c + CW'(1));
    end else begin
      left_init = cnt_r;
      ptr_init  = '0;
    end
  end

  assign ptr_step = is_open ? (ptr_r - AW'(1)) : (ptr_r + AW'(1));
  assign wr_tgt   = is_open ? (ptr_r + AW'(1)) : (is_close ? (ptr_r - AW'(1)) : ptr_r);

  assign walk_more = (left_r != '0) && !hit_r;
  assign rd_en     = cmd.walk && walk_more;
  assign match     = pend_r && is_find && !hit_r && (rd_data_r == value_r);
  assign found_nxt = sle_pkg::POS_W'(CW'(pend_idx_r) + CW'(1));

  assign sts.walk_req  = (chk_status == sle_pkg::ST_OK) && (is_open || is_close || is_find);
  assign sts.walk_more = walk_more;
  assign sts.pend      = pend_r;

  // single write port: shift moves during the walk, the new value at finish
  assign val_we = cmd.finish && (chk_status == sle_pkg::ST_OK) && is_grow;
  assign val_wa = (op_r == sle_pkg::OP_PUSH_BACK) ? AW'(cnt_r) :
                  ((op_r == sle_pkg::OP_INSERT) ? AW'(pos_m1) : '0);
  assign sh_we  = pend_r && (is_open || is_close);
  assign mem_we = sh_we || val_we;
  assign mem_wa = sh_we ? pend_idx_r : val_wa;
  assign mem_wd = sh_we ? rd_data_r : value_r;

  always_comb begin
    cnt_nxt = cnt_r;
    if (chk_status == sle_pkg::ST_OK) begin
      if (is_grow) cnt_nxt = cnt_r + CW'(1);
      else if (is_shrink) cnt_nxt = cnt_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_wa] <= mem_wd;
    if (rd_en) rd_data_r <= mem[ptr_r];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      left_r <= '0;
      pend_r <= 1'b0;
      hit_r  <= 1'b0;
    end else begin
      pend_r <= rd_en;
      if (cmd.load) begin
        hit_r <= 1'b0;
      end else if (match) begin
        hit_r <= 1'b1;
      end
      if (cmd.walk_init) begin
        left_r <= left_init;
      end else if (rd_en) begin
        left_r <= left_r - CW'(1);
      end
      if (cmd.finish) cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r    <= in_op;
      value_r <= in_value;
      pos_r   <= in_position;
      found_r <= '0;
    end else if (match) begin
      found_r <= found_nxt;
    end
    if (cmd.walk_init) begin
      ptr_r <= ptr_init;
    end else if (rd_en) begin
      ptr_r <= ptr_step;
    end
    if (rd_en) pend_idx_r <= wr_tgt;
    if (cmd.finish) begin
      status_r    <= fin_status;
      found_out_r <= found_r;
      count_out_r <= sle_pkg::POS_W'(cnt_nxt);
    end
  end

  assign out_status         = status_r;
  assign out_found_position = found_out_r;
  assign out_count          = count_out_r;

endmodule

@@ rtl/sequential_list_engine.sv @@
// ----------------------------------------------------------------------------
// sequential_list_engine: ordered list with push, pop, find, insert, erase
// Top level joining the request sequencer and the list datapath.
// ----------------------------------------------------------------------------
// Push back, pop back, the unused code and rejected requests go from check
// straight to finish; shifting ops and find walk over n entries first, n being
// the entries moved or compared, at most DEPTH, one a cycle through the read port.
// Throughput: one request in flight; the next is taken the cycle after the result
// registers, later while a stalled result holds the finish. Reset: count cleared.
module sequential_list_engine #(
  parameter int DEPTH = sle_pkg::DEPTH_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic        [sle_pkg::OP_W-1:0]    in_op,
  input  logic signed [sle_pkg::VAL_W-1:0]   in_value,
  input  logic        [sle_pkg::POS_W-1:0]   in_position,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic        [sle_pkg::ST_W-1:0]    out_status,
  output logic        [sle_pkg::POS_W-1:0]   out_found_position,
  output logic        [sle_pkg::POS_W-1:0]   out_count
);

  sle_pkg::sle_cmd_t cmd;
  sle_pkg::sle_sts_t sts;

  sle_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  sle_dpath #(
    .DEPTH (DEPTH)
  ) u_dpath (
    .clk                (clk),
    .rst_n              (rst_n),
    .cmd                (cmd),
    .sts                (sts),
    .in_op              (in_op),
    .in_value           (in_value),
    .in_position        (in_position),
    .out_status         (out_status),
    .out_found_position (out_found_position),
    .out_count          (out_count)
  );

  // a shift or compare only ever completes inside the walk
  ast_pend_in_walk: assert property (@(posedge clk) disable iff (!rst_n)
    sts.pend |-> cmd.walk)
    else $error("read pending outside the walk");

  // the finishing write never competes with a shift write
  ast_finish_no_pend: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.finish |-> !sts.pend)
    else $error("finish while a shift write is pending");

  // a result only appears after a finish step
  ast_result_from_finish: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(cmd.finish))
    else $error("result raised without a finish");

  // no finish step can come in the cycle after a request is taken
  ast_no_instant_result: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> !cmd.finish)
    else $error("finish directly after a request transaction");

endmodule

@@ test/sequential_list_engine_test.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// sequential_list_engine_test: self-checking bench for the list engine
// Drives push, pop, find, insert, erase and the unused code through the
// request channel with random gaps and back-pressure. A scoreboard keeps its
// own copy of the list, works out each result when a request transaction is
// accepted, and checks every result transaction against it in order.
// ----------------------------------------------------------------------------
module sequential_list_engine_test;
  import sle_pkg::*;

  localparam int DEPTH = DEPTH_DEF;
  localparam logic [OP_W-1:0] OP_UNUSED = 3'd7;
  localparam int RANDOM_ITEMS = 1750;
  localparam int TAIL_CYCLES = 80;

  localparam int PH_GROW   = 0;
  localparam int PH_SHRINK = 1;
  localparam int PH_MIXED  = 2;

  typedef struct packed {
    logic [ST_W-1:0]  status;
    logic [POS_W-1:0] found;
    logic [POS_W-1:0] count;
  } list_result_t;

  class list_scoreboard;
    logic signed [VAL_W-1:0] stored [DEPTH];
    int unsigned list_len;
    list_result_t awaited_q [$];
    int unsigned errors;
    int unsigned checked;
    int unsigned op_seen [8];
    int unsigned status_seen [5];

    function new();
      list_len = 0;
      errors = 0;
      checked = 0;
      foreach (op_seen[i]) op_seen[i] = 0;
      foreach (status_seen[i]) status_seen[i] = 0;
    endfunction

    // shift entries at and above idx up by one
    function void open_gap(int unsigned idx);
      for (int unsigned i = list_len; i > idx; i--) stored[i] = stored[i - 1];
    endfunction

    // shift entries above idx down by one
    function void close_gap(int unsigned idx);
      for (int unsigned i = idx; i + 1 < list_len; i++) stored[i] = stored[i + 1];
    endfunction

    function void note_request(logic [OP_W-1:0] op, logic signed [VAL_W-1:0] val,
                               logic [POS_W-1:0] pos);
      list_result_t res;
      int unsigned p;
      res.status = ST_OK;
      res.found = '0;
      p = int'(pos);
      case (op)
        OP_PUSH_BACK: begin
          if (list_len >= DEPTH) begin
            res.status = ST_FULL;
          end else begin
            stored[list_len] = val;
            list_len++;
          end
        end
        OP_POP_BACK: begin
          if (list_len == 0) res.status = ST_EMPTY;
          else list_len--;
        end
        OP_PUSH_FRONT: begin
          if (list_len >= DEPTH) begin
            res.status = ST_FULL;
          end else begin
            open_gap(0);
            stored[0] = val;
            list_len++;
          end
        end
        OP_POP_FRONT: begin
          if (list_len == 0) begin
            res.status = ST_EMPTY;
          end else begin
            close_gap(0);
            list_len--;
          end
        end
        OP_FIND: begin
          res.status = ST_NOTFOUND;
          for (int unsigned i = 0; i < list_len; i++) begin
            if (stored[i] == val) begin
              res.status = ST_OK;
              res.found = POS_W'(i + 1);
              break;
            end
          end
        end
        OP_INSERT: begin
          if (list_len >= DEPTH) begin
            res.status = ST_FULL;
          end else if (p < 1 || p > list_len + 1) begin
            res.status = ST_BADPOS;
          end else begin
            open_gap(p - 1);
            stored[p - 1] = val;
            list_len++;
          end
        end
        OP_ERASE: begin
          if (list_len == 0) begin
            res.status = ST_EMPTY;
          end else if (p < 1 || p > list_len) begin
            res.status = ST_BADPOS;
          end else begin
            close_gap(p - 1);
            list_len--;
          end
        end
        default: ;
      endcase
      res.count = list_len[POS_W-1:0];
      op_seen[op]++;
      status_seen[res.status]++;
      awaited_q.push_back(res);
    endfunction

    function void check_result(logic [ST_W-1:0] st, logic [POS_W-1:0] fp,
                               logic [POS_W-1:0] cnt);
      list_result_t want;
      if (awaited_q.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("%0t: result with nothing outstanding: status %0d found %0d count %0d",
                   $realtime, st, fp, cnt);
        return;
      end
      want = awaited_q.pop_front();
      checked++;
      if (st !== want.status || fp !== want.found || cnt !== want.count) begin
        errors++;
        if (errors <= 10)
          $display("%0t: result %0d mismatch: status %0d/%0d found %0d/%0d count %0d/%0d",
                   $realtime, checked, st, want.status, fp, want.found, cnt, want.count);
      end
    endfunction
  endclass

  logic                     clk;
  logic                     rst_n;
  logic                     in_valid;
  logic                     in_stall;
  logic [OP_W-1:0]          in_op;
  logic signed [VAL_W-1:0]  in_value;
  logic [POS_W-1:0]         in_position;
  logic                     out_valid;
  logic                     out_stall;
  logic [ST_W-1:0]          out_status;
  logic [POS_W-1:0]         out_found_position;
  logic [POS_W-1:0]         out_count;

  list_scoreboard sb = new();
  bit quiet;

  sequential_list_engine i_dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_op              (in_op),
    .in_value           (in_value),
    .in_position        (in_position),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_status         (out_status),
    .out_found_position (out_found_position),
    .out_count          (out_count)
  );

  initial clk = 1'b0;
  always #1 clk = ~clk;

  // mostly short gaps, now and then a long one; none in quiet stretches
  function automatic int pick_gap();
    int r;
    if (quiet) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic signed [VAL_W-1:0] pick_value();
    int r;
    r = $urandom_range(0, 99);
    // a narrow pool gives repeated values, so first-match order matters
    if (r < 35) return $signed($urandom_range(0, 15)) - 8;
    if (r < 45) begin
      case ($urandom_range(0, 3))
        0: return 32'h8000_0000;
        1: return 32'h7FFF_FFFF;
        2: return 32'hFFFF_FFFF;
        default: return 32'h0;
      endcase
    end
    return $urandom;
  endfunction

  function automatic logic [POS_W-1:0] pick_bad_position(int unsigned just_past);
    case ($urandom_range(0, 2))
      0: return '0;
      1: return POS_W'(just_past);
      default: return POS_W'($urandom_range(0, 127));
    endcase
  endfunction

  // hold the request until it is taken, then leave a random gap
  task automatic send_request(input logic [OP_W-1:0] op, input logic signed [VAL_W-1:0] val,
                              input logic [POS_W-1:0] pos);
    int gap;
    in_valid <= 1'b1;
    in_op <= op;
    in_value <= val;
    in_position <= pos;
    do @(posedge clk); while (in_stall !== 1'b0);
    sb.note_request(op, val, pos);
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (sb.awaited_q.size() != 0);
  endtask

  task automatic random_request(input int phase);
    logic [OP_W-1:0] op;
    logic signed [VAL_W-1:0] val;
    logic [POS_W-1:0] pos;
    int r;
    int unsigned len;
    len = sb.list_len;
    r = $urandom_range(0, 99);
    case (phase)
      PH_GROW: begin
        if (r < 30) op = OP_PUSH_BACK;
        else if (r < 50) op = OP_PUSH_FRONT;
        else if (r < 75) op = OP_INSERT;
        else if (r < 85) op = OP_FIND;
        else if (r < 90) op = OP_POP_BACK;
        else if (r < 95) op = OP_ERASE;
        else if (r < 98) op = OP_POP_FRONT;
        else op = OP_UNUSED;
      end
      PH_SHRINK: begin
        if (r < 25) op = OP_POP_BACK;
        else if (r < 45) op = OP_POP_FRONT;
        else if (r < 75) op = OP_ERASE;
        else if (r < 85) op = OP_FIND;
        else if (r < 90) op = OP_PUSH_BACK;
        else if (r < 95) op = OP_INSERT;
        else if (r < 98) op = OP_PUSH_FRONT;
        else op = OP_UNUSED;
      end
      default: begin
        op = OP_W'($urandom_range(0, 6));
        if (r < 5) op = OP_UNUSED;
      end
    endcase

    val = pick_value();
    pos = POS_W'($urandom_range(0, 127));
    r = $urandom_range(0, 99);
    if (op == OP_FIND && len > 0 && r < 60) val = sb.stored[$urandom_range(0, len - 1)];
    if (op == OP_INSERT) begin
      if (r < 85) pos = POS_W'($urandom_range(1, len + 1));
      else pos = pick_bad_position(len + 2);
    end
    if (op == OP_ERASE) begin
      if (len > 0 && r < 85) pos = POS_W'($urandom_range(1, len));
      else pos = pick_bad_position(len + 1);
    end
    send_request(op, val, pos);
  endtask

  // result side: check on every taken transaction, stall at random
  initial begin
    int stall_left;
    stall_left = 0;
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n === 1'b1 && out_valid === 1'b1 && out_stall === 1'b0)
        sb.check_result(out_status, out_found_position, out_count);
      if (stall_left > 0) stall_left--;
      else stall_left = pick_gap();
      out_stall <= (stall_left > 0);
    end
  end

  initial begin
    int sent;
    int seg_len;
    int phase;
    quiet = 1'b0;
    rst_n <= 1'b0;
    in_valid <= 1'b0;
    in_op <= OP_PUSH_BACK;
    in_value <= '0;
    in_position <= '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // empty list, bad positions, extremes, shifting in the middle
    send_request(OP_POP_BACK, 32'h1234_5678, 7'd0);
    send_request(OP_POP_FRONT, 32'hFFFF_FFFF, 7'd127);
    send_request(OP_ERASE, 32'h0, 7'd1);
    send_request(OP_FIND, 32'h0, 7'd0);
    send_request(OP_INSERT, 32'h1, 7'd0);
    send_request(OP_INSERT, 32'h1, 7'd2);
    send_request(OP_INSERT, 32'h8000_0000, 7'd1);
    send_request(OP_PUSH_BACK, 32'h7FFF_FFFF, 7'd127);
    send_request(OP_PUSH_FRONT, 32'hFFFF_FFFF, 7'd64);
    send_request(OP_INSERT, 32'h0, 7'd4);
    send_request(OP_INSERT, 32'h5, 7'd127);
    send_request(OP_FIND, 32'h7FFF_FFFF, 7'd0);
    send_request(OP_FIND, 32'd12345, 7'd127);
    send_request(OP_ERASE, 32'h0, 7'd0);
    send_request(OP_ERASE, 32'h0, 7'd5);
    send_request(OP_ERASE, 32'hFFFF_FFFF, 7'd2);
    send_request(OP_UNUSED, 32'hFFFF_FFFF, 7'd127);
    send_request(OP_POP_FRONT, 32'h0, 7'd0);
    send_request(OP_POP_BACK, 32'h0, 7'd0);
    send_request(OP_INSERT, 32'h5, 7'd2);
    send_request(OP_ERASE, 32'h0, 7'd2);
    send_request(OP_ERASE, 32'h0, 7'd1);
    drain();

    // random growing, shrinking and mixed runs so the list hits full and empty
    sent = 0;
    phase = PH_GROW;
    seg_len = 160;
    while (sent < RANDOM_ITEMS) begin
      quiet = ($urandom_range(0, 3) == 0);
      for (int i = 0; i < seg_len && sent < RANDOM_ITEMS; i++) begin
        random_request(phase);
        sent++;
      end
      if ($urandom_range(0, 3) == 0) drain();
      phase = $urandom_range(PH_GROW, PH_MIXED);
      seg_len = $urandom_range(40, 160);
    end
    quiet = 1'b0;
    drain();
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("Ran %0d requests: push_back %0d pop_back %0d push_front %0d pop_front %0d",
             sb.checked + sb.awaited_q.size(), sb.op_seen[OP_PUSH_BACK],
             sb.op_seen[OP_POP_BACK], sb.op_seen[OP_PUSH_FRONT], sb.op_seen[OP_POP_FRONT]);
    $display("  find %0d insert %0d erase %0d unused %0d; ok %0d full %0d empty %0d bad %0d miss %0d",
             sb.op_seen[OP_FIND], sb.op_seen[OP_INSERT], sb.op_seen[OP_ERASE],
             sb.op_seen[OP_UNUSED], sb.status_seen[ST_OK], sb.status_seen[ST_FULL],
             sb.status_seen[ST_EMPTY], sb.status_seen[ST_BADPOS], sb.status_seen[ST_NOTFOUND]);
    if (sb.awaited_q.size() != 0)
      $display("%0d results never arrived", sb.awaited_q.size());
    if (sb.errors != 0) $display("%0d failing results", sb.errors);
    if (sb.errors == 0 && sb.awaited_q.size() == 0) begin
      $display("sequential_list_engine verification clean");
    end else begin
      $display("sequential_list_engine verification failed");
    end
    $finish;
  end

  initial begin
    #2_400_000;
    $display("Run timed out with %0d results outstanding", sb.awaited_q.size());
    $display("sequential_list_engine verification failed");
    $finish;
  end

endmodule

@@ sim.f @@
rtl/sle_pkg.sv
rtl/sle_ctrl.sv
rtl/sle_dpath.sv
rtl/sequential_list_engine.sv
test/sequential_list_engine_test.sv
